// ----- rtl/ebc_pkg.sv -----
// Shared types and constants for the envelope blend controller.
package ebc_pkg;

  // Level format: unsigned fixed point with 15 fraction bits
  localparam int unsigned LevelFracBits = 15;
  localparam int unsigned LevelW        = 16;
  localparam logic [LevelW-1:0] OneLevel = LevelW'(1) << LevelFracBits;

  // Falloff clamp limits, rounded from 0.05 and 0.4 of full scale
  localparam int unsigned FallLoInt = (32'(OneLevel) * 5 + 50) / 100;
  localparam int unsigned FallHiInt = (32'(OneLevel) * 4 + 5) / 10;
  localparam int unsigned FallW     = $clog2(FallHiInt + 1);
  localparam logic [FallW-1:0] FallLo = FallW'(FallLoInt);
  localparam logic [FallW-1:0] FallHi = FallW'(FallHiInt);

  // Quotient bits produced by the restoring divider
  localparam int unsigned DivSteps = LevelFracBits;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Register map
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DEPTH     = 2'd1,
    REG_INVERT    = 2'd2,
    REG_DECAY     = 2'd3
  } ebc_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] threshold_level;
    logic [LevelW-1:0] blend_depth;
    logic              invert_mode;
    logic [15:0]       block_decay;
  } ebc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_T,
    ST_MUL_S,
    ST_DONE
  } ebc_state_e;

endpackage

// ----- rtl/ebc_regs.sv -----
// APB configuration register file for the envelope blend controller.
module ebc_regs
  import ebc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output ebc_cfg_t         cfg_o
);

  ebc_cfg_t cfg_q;
  ebc_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ebc_reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  // Write the addressed register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_level <= '0;
      cfg_q.blend_depth     <= OneLevel;
      cfg_q.invert_mode     <= 1'b0;
      cfg_q.block_decay     <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD: cfg_q.threshold_level <= pwdata[LevelW-1:0];
        REG_DEPTH:     cfg_q.blend_depth     <= pwdata[LevelW-1:0];
        REG_INVERT:    cfg_q.invert_mode     <= pwdata[0];
        REG_DECAY:     cfg_q.block_decay     <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_THRESHOLD: prdata = DataW'(cfg_q.threshold_level);
      REG_DEPTH:     prdata = DataW'(cfg_q.blend_depth);
      REG_INVERT:    prdata = DataW'(cfg_q.invert_mode);
      REG_DECAY:     prdata = DataW'(cfg_q.block_decay);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/envelope_blend_controller_top.sv -----
// Top level of the envelope blend controller: sequencer, divider step and shared multiplier.
// Sequencing: idle goes straight to MUL_S and DONE when the target is zero, through MUL_T,
// MUL_S and DONE when the ratio saturates, and first through the 15-step restoring divider
// (one quotient bit a cycle) otherwise. Requests stall while the sequencer is not idle.
// A new request is taken while the previous result still waits in the output register.
// Reset (asynchronous, active low) clears state, held level and blend, and loads defaults.
module envelope_blend_controller_top
  import ebc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // Request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [LevelW-1:0] envelope_level_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LevelW-1:0] blend_value_o,
  output logic [LevelW-1:0] target_value_o,
  output logic              capture_trigger_o
);

  ebc_cfg_t   cfg;
  ebc_state_e state_q, state_d;

  logic [LevelW-1:0] prev_level_q;
  logic [LevelW-1:0] smooth_q;
  logic [LevelW-1:0] ratio_q;
  logic [LevelW-1:0] target_q;
  logic [FallW-1:0]  fall_q;
  logic [FallW-1:0]  rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              trig_q;

  logic              out_valid_q;
  logic [LevelW-1:0] out_blend_q;
  logic [LevelW-1:0] out_target_q;
  logic              out_trig_q;

  logic in_acc;
  logic out_free;

  ebc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Saturate registers and set up the distance and falloff span
  logic [LevelW-1:0] thr_sat, depth_sat, head, span, lvl_dist;
  logic [FallW-1:0]  fall;
  logic              active, trig;

  always_comb begin
    thr_sat   = (cfg.threshold_level > OneLevel) ? OneLevel : cfg.threshold_level;
    depth_sat = (cfg.blend_depth > OneLevel) ? OneLevel : cfg.blend_depth;
    head      = OneLevel - thr_sat;
    if (!cfg.invert_mode) begin
      trig     = (prev_level_q >= thr_sat) && (envelope_level_i < thr_sat);
      active   = (thr_sat != '0) && (envelope_level_i < thr_sat);
      lvl_dist = thr_sat - envelope_level_i;
      span     = thr_sat;
    end else begin
      trig     = (prev_level_q <= thr_sat) && (envelope_level_i > thr_sat);
      active   = (head != '0) && (envelope_level_i > thr_sat);
      lvl_dist = envelope_level_i - thr_sat;
      span     = head;
    end
    if (span < LevelW'(FallLo)) begin
      fall = FallLo;
    end else if (span > LevelW'(FallHi)) begin
      fall = FallHi;
    end else begin
      fall = span[FallW-1:0];
    end
  end

  // One restoring divider step: shift the remainder, try the subtraction
  logic [FallW:0]   rem2;
  logic             qbit;
  logic [FallW-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_q, 1'b0};
    qbit    = rem2 >= {1'b0, fall_q};
    rem_nxt = qbit ? FallW'(rem2 - {1'b0, fall_q}) : rem_q << 1;
  end

  // Shared multiplier: ratio times depth, then blend gap times decay
  logic [LevelW-1:0]   mul_a, mul_b;
  logic [2*LevelW-1:0] prod;
  logic                up;
  logic [LevelW-1:0]   gap_in, step, blend_nxt;

  always_comb begin
    up     = smooth_q >= target_q;
    gap_in = up ? (smooth_q - target_q) : (target_q - smooth_q);
    if (state_q == ST_MUL_T) begin
      mul_a = ratio_q;
      mul_b = depth_sat;
    end else begin
      mul_a = gap_in;
      mul_b = cfg.block_decay;
    end
    prod = mul_a * mul_b;
    step = prod[2*LevelW-1:LevelW];
    if (step <= LevelW'(1)) begin
      blend_nxt = target_q;
    end else if (up) begin
      blend_nxt = target_q + step;
    end else begin
      blend_nxt = target_q - step;
    end
  end

  assign in_acc     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!active) begin
            state_d = ST_MUL_S;
          end else if (lvl_dist >= LevelW'(fall)) begin
            state_d = ST_MUL_T;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV:   if (cnt_q == CntW'(DivSteps - 1)) state_d = ST_MUL_T;
      ST_MUL_T: state_d = ST_MUL_S;
      ST_MUL_S: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Hold the item state and step the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= '0;
      smooth_q     <= '0;
    end else begin
      if (in_acc) begin
        prev_level_q <= envelope_level_i;
      end
      if (state_q == ST_MUL_S) begin
        smooth_q <= blend_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        trig_q   <= trig;
        fall_q   <= fall;
        rem_q    <= lvl_dist[FallW-1:0];
        cnt_q    <= '0;
        ratio_q  <= OneLevel;
        target_q <= '0;
      end
      ST_DIV: begin
        rem_q   <= rem_nxt;
        cnt_q   <= cnt_q + CntW'(1);
        ratio_q <= (cnt_q == '0) ? LevelW'(qbit) : {ratio_q[LevelW-2:0], qbit};
      end
      ST_MUL_T: target_q <= prod[LevelFracBits +: LevelW];
      ST_MUL_S, ST_DONE: ;
      default: ;
    endcase
  end

  // Drop the result into the output register once it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_blend_q  <= smooth_q;
      out_target_q <= target_q;
      out_trig_q   <= trig_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign blend_value_o     = out_blend_q;
  assign target_value_o    = out_target_q;
  assign capture_trigger_o = out_trig_q;

endmodule

// ----- verif/envelope_blend_controller_top_tb.sv -----
// Self-checking testbench for the envelope blend controller top level.
`timescale 1ns / 100ps

module envelope_blend_controller_top_tb;
  import ebc_pkg::*;

  // Full scale and falloff limits of the level format
  localparam longint unsigned LevelOne = 64'd1 << 15;
  localparam longint unsigned FallMin  = (LevelOne * 5 + 50) / 100;
  localparam longint unsigned FallMax  = (LevelOne * 4 + 5) / 10;
  localparam int unsigned     QuietLimit  = 4000;
  localparam int unsigned     SettleCycles = 24;
  localparam int unsigned     RandomPhases = 8;
  localparam int unsigned     PhaseLevels  = 100;

  typedef struct {
    logic [15:0] blend;
    logic [15:0] target;
    logic        trigger;
  } blend_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [LevelW-1:0] envelope_level_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [LevelW-1:0] blend_value_o;
  logic [LevelW-1:0] target_value_o;
  logic              capture_trigger_o;

  // Predictor copy of the registers and the held state
  logic [15:0] thr_reg;
  logic [15:0] depth_reg;
  logic        invert_reg;
  logic [15:0] decay_reg;
  logic [15:0] prev_level;
  logic [15:0] held_blend;

  blend_result_t expected_blends[$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady = 1'b0;

  envelope_blend_controller_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .envelope_level_i  (envelope_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .blend_value_o     (blend_value_o),
    .target_value_o    (target_value_o),
    .capture_trigger_o (capture_trigger_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out trigger, target and slewed blend for one block, and advance the state
  function automatic blend_result_t predict_blend(input logic [15:0] lvl);
    longint unsigned thr, depth, lvl_dist, span, fall, ratio, tgt, cur, nxt, gap;
    blend_result_t   res;
    thr      = (thr_reg > LevelOne) ? LevelOne : thr_reg;
    depth    = (depth_reg > LevelOne) ? LevelOne : depth_reg;
    lvl_dist = 0;
    span     = 0;
    tgt      = 0;
    if (!invert_reg) begin
      res.trigger = (prev_level >= thr) && (lvl < thr);
      if (thr != 0 && lvl < thr) begin
        lvl_dist = thr - lvl;
        span     = thr;
      end
    end else begin
      res.trigger = (prev_level <= thr) && (lvl > thr);
      if (thr != LevelOne && lvl > thr) begin
        lvl_dist = lvl - thr;
        span     = LevelOne - thr;
      end
    end
    prev_level = lvl;
    if (lvl_dist != 0) begin
      fall  = (span < FallMin) ? FallMin : ((span > FallMax) ? FallMax : span);
      ratio = (lvl_dist << 15) / fall;
      if (ratio > LevelOne) ratio = LevelOne;
      tgt = (ratio * depth) >> 15;
    end
    // Slew toward the target, truncating toward it, and snap when within one step
    cur = held_blend;
    if (cur >= tgt) begin
      nxt = tgt + (((cur - tgt) * decay_reg) >> 16);
      gap = nxt - tgt;
    end else begin
      nxt = tgt - (((tgt - cur) * decay_reg) >> 16);
      gap = tgt - nxt;
    end
    if (gap <= 1) nxt = tgt;
    held_blend = nxt[15:0];
    res.blend  = nxt[15:0];
    res.target = tgt[15:0];
    return res;
  endfunction

  // Write one register over the configuration port, then update the predictor copy
  task automatic write_reg(input ebc_reg_e idx, input logic [31:0] val);
    // hold off until no request is left in flight
    in_valid_i <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg    = val[15:0];
      REG_DEPTH:     depth_reg  = val[15:0];
      REG_INVERT:    invert_reg = val[0];
      REG_DECAY:     decay_reg  = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_setup(input logic [15:0] thr, input logic [15:0] depth,
                             input logic inv, input logic [15:0] decay);
    write_reg(REG_THRESHOLD, {16'h0, thr});
    write_reg(REG_DEPTH, {16'h0, depth});
    write_reg(REG_INVERT, {31'h0, inv});
    write_reg(REG_DECAY, {16'h0, decay});
  endtask

  // Offer one level request, with random idle cycles ahead of it; hold it while stalled
  task automatic push_level(input logic [15:0] lvl);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    envelope_level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    expected_blends.push_back(predict_blend(lvl));
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result checker: compare each accepted result with the oldest expectation
  initial begin : result_monitor
    blend_result_t want;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_blends.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding: blend %0d target %0d trigger %0d",
                 blend_value_o, target_value_o, capture_trigger_o);
        end else begin
          want = expected_blends.pop_front();
          if (blend_value_o !== want.blend) begin
            mismatches++;
            $error("blend_value: expected %0d, got %0d", want.blend, blend_value_o);
          end
          if (target_value_o !== want.target) begin
            mismatches++;
            $error("target_value: expected %0d, got %0d", want.target, target_value_o);
          end
          if (capture_trigger_o !== want.trigger) begin
            mismatches++;
            $error("capture_trigger: expected %0d, got %0d", want.trigger, capture_trigger_o);
          end
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < 9);
    end
  end

  // Abort when nothing moves on either channel for too long
  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Reset defaults: zero threshold in normal mode never gives a target
  task automatic test_zero_threshold();
    push_level(16'h0000);
    push_level(16'hFFFF);
    push_level(16'h8000);
    settle_block();
  endtask

  // Normal mode: downward crossings, level at threshold, both falloff clamps
  task automatic test_normal_mode();
    write_setup(16'd16384, 16'd32768, 1'b0, 16'd0);
    push_level(16'd20000);
    push_level(16'd10000);
    push_level(16'd0);
    push_level(16'd16384);
    push_level(16'd16383);
    push_level(16'hFFFF);
    write_reg(REG_THRESHOLD, 32'd100);
    push_level(16'd40);
    push_level(16'd100);
    settle_block();
  endtask

  // Invert mode: zero headroom, upward crossings, wide headroom clamped
  task automatic test_invert_mode();
    write_setup(16'd32768, 16'd32768, 1'b1, 16'd0);
    push_level(16'd0);
    push_level(16'hFFFF);
    write_reg(REG_THRESHOLD, 32'd30000);
    push_level(16'd30000);
    push_level(16'd31000);
    push_level(16'hFFFF);
    write_reg(REG_THRESHOLD, 32'd0);
    push_level(16'd0);
    push_level(16'd1);
    settle_block();
  endtask

  // Threshold and depth above full scale saturate; zero depth kills the target
  task automatic test_register_saturation();
    write_setup(16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    push_level(16'hFFFF);
    push_level(16'd0);
    write_reg(REG_DEPTH, 32'd0);
    push_level(16'd1000);
    settle_block();
  endtask

  // Slew: slowest retention, half retention, and the snap near the target
  task automatic test_slew_decay();
    write_setup(16'd16384, 16'd32768, 1'b0, 16'hFFFF);
    push_level(16'd0);
    push_level(16'd0);
    write_reg(REG_DECAY, 32'h0000_8000);
    push_level(16'd16384);
    push_level(16'd16000);
    settle_block();
  endtask

  function automatic logic [15:0] pick_scale_reg();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_decay_reg();
    case ($urandom_range(4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Mostly levels around the threshold so that crossings are frequent
  function automatic logic [15:0] pick_envelope();
    int lvl;
    if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
    lvl = int'(thr_reg) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(16384));
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    return 16'(lvl);
  endfunction

  // Random traffic in phases, each under a fresh register setting
  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      steady = (phase == 4);
      write_setup(pick_scale_reg(), pick_scale_reg(), 1'($urandom_range(1)), pick_decay_reg());
      for (int unsigned n = 0; n < PhaseLevels; n++) begin
        push_level(pick_envelope());
        // now and then hold off until the block has caught up
        if ($urandom_range(49) == 0) settle_block();
      end
      settle_block();
    end
    steady = 1'b0;
  endtask

  initial begin
    thr_reg    = 16'd0;
    depth_reg  = 16'd32768;
    invert_reg = 1'b0;
    decay_reg  = 16'd0;
    prev_level = 16'd0;
    held_blend = 16'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_threshold();
    test_normal_mode();
    test_invert_mode();
    test_register_saturation();
    test_slew_decay();
    test_random_traffic();
    settle_block();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
